// ----- design/lc4_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc4_pkg
// Shared types, codes and helpers for the instruction step processor.
// ----------------------------------------------------------------------------
package lc4_pkg;

  localparam logic [15:0] PC_RESET   = 16'h8200;
  localparam logic [15:0] PSR_RESET  = 16'h8002;
  localparam logic [15:0] USER_DATA  = 16'h2000;
  localparam logic [15:0] OS_CODE    = 16'h8000;
  localparam logic [15:0] OS_DATA    = 16'hA000;
  localparam logic [15:0] OS_TOP     = 16'hC000;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_PC_DATA = 2'd1,
    STAT_BAD_ADR = 2'd2,
    STAT_PRIV    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_BR      = 4'd0,
    OP_ARITH   = 4'd1,
    OP_CMP     = 4'd2,
    OP_JSR     = 4'd4,
    OP_LOGIC   = 4'd5,
    OP_LDR     = 4'd6,
    OP_STR     = 4'd7,
    OP_RTI     = 4'd8,
    OP_CONST   = 4'd9,
    OP_SHIFT   = 4'd10,
    OP_JMP     = 4'd12,
    OP_HICONST = 4'd13,
    OP_TRAP    = 4'd15
  } opcode_t;

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic [2:0] ARITH_ADD = 3'd0;
  localparam logic [2:0] ARITH_MUL = 3'd1;
  localparam logic [2:0] ARITH_SUB = 3'd2;
  localparam logic [2:0] LOGIC_AND = 3'd0;
  localparam logic [2:0] LOGIC_NOT = 3'd1;
  localparam logic [2:0] LOGIC_OR  = 3'd2;
  localparam logic [1:0] CMP_S     = 2'd0;
  localparam logic [1:0] CMP_U     = 2'd1;
  localparam logic [1:0] CMP_SI    = 2'd2;
  localparam logic [1:0] SH_SLL    = 2'd0;
  localparam logic [1:0] SH_SRA    = 2'd1;
  localparam logic [1:0] SH_SRL    = 2'd2;
  localparam logic [1:0] SH_MOD    = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_FETCH, ST_DECODE, ST_READ_S, ST_READ_T,
    ST_READ_D, ST_ADDR, ST_EXEC, ST_DIV, ST_COMMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic latch_in;
    logic load_wr;
    logic fetch;
    logic decode;
    logic read_s;
    logic read_t;
    logic read_d;
    logic addr;
    logic exec;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_full;
    logic is_divmod;
    logic div_busy;
  } dp_stat_t;

  function automatic logic [15:0] cmp3(input logic signed [16:0] a,
                                       input logic signed [16:0] b);
    if (a > b) return 16'h0001;
    if (a == b) return 16'h0000;
    return 16'hFFFF;
  endfunction

  function automatic logic [2:0] cond_of(input logic [15:0] v);
    if (v == 16'h0000) return 3'b010;
    if (v[15]) return 3'b100;
    return 3'b001;
  endfunction

endpackage

// ----- design/lc4_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc4_div
// Restoring unsigned 16-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lc4_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] quotient,
  output logic [15:0] remainder
);
  logic [16:0] rem;
  logic [15:0] quo;
  logic [15:0] dsr;
  logic [3:0]  cnt;
  logic [16:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem[15:0], quo[15]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
      quo <= {quo[14:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem[15:0];
endmodule

// ----- design/lc4_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc4_datapath
// Memory, register file, architectural state, execute logic and result register.
// ----------------------------------------------------------------------------
module lc4_datapath #(
  parameter int MEM_WORDS = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  lc4_pkg::dp_cmd_t  cmd,
  output lc4_pkg::dp_stat_t st,
  input  logic [15:0]       load_address,
  input  logic [15:0]       load_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        status,
  output logic [15:0]       pc_before,
  output logic [15:0]       instruction,
  output logic [15:0]       next_pc,
  output logic              reg_write,
  output logic [2:0]        reg_dest,
  output logic [15:0]       reg_value,
  output logic              mem_write,
  output logic [15:0]       mem_address,
  output logic [15:0]       mem_data,
  output logic [2:0]        nzp,
  output logic              privileged
);
  import lc4_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rf [8];
  logic [15:0] mem_q, rf_q;
  logic [AW-1:0] clr_addr;

  logic [15:0] pc, psr;
  logic [15:0] ld_addr, ld_data;
  logic [15:0] insn, rs, rt, rdv, r7, ldv;

  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_we;
  logic [2:0]    rf_raddr, rf_waddr;
  logic [15:0]   rf_wdata;
  logic          rf_we;

  logic [15:0] quo, rmd;
  logic        div_busy;

  // execute results
  logic [3:0]  op;
  logic [2:0]  d;
  logic [15:0] ea, val, nxt, psr_new, addr_o;
  logic        wr, memw, setcc, ok;
  logic [2:0]  rd;
  status_t     stat;
  logic [31:0] prod;
  logic [15:0] pc_inc;

  assign op     = insn[15:12];
  assign d      = insn[11:9];
  assign ea     = rs + {{10{insn[5]}}, insn[5:0]};
  assign pc_inc = pc + 16'd1;
  assign prod   = rs * rt;

  lc4_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.exec && st.is_divmod),
    .dividend  (rs),
    .divisor   (rt),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rmd)
  );

  assign st.clear_done = clr_addr == {AW{1'b1}};
  assign st.out_full   = out_valid;
  assign st.div_busy   = div_busy;
  assign st.is_divmod  = (op == OP_ARITH && !insn[5] && insn[5:3] >= 3'd3) ||
                         (op == OP_SHIFT && insn[5:4] == SH_MOD);

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear) clr_addr <= clr_addr + 1'b1;
  end

  // memory ports
  assign mem_raddr = cmd.addr ? ea[AW-1:0] : pc[AW-1:0];
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (cmd.load_wr) begin
      mem_we    = 1'b1;
      mem_waddr = ld_addr[AW-1:0];
      mem_wdata = ld_data;
    end else if (cmd.commit && ok && memw) begin
      mem_we    = 1'b1;
      mem_waddr = ea[AW-1:0];
      mem_wdata = rdv;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // register file ports
  always_comb begin
    rf_raddr = 3'd7;
    if (cmd.decode) rf_raddr = mem_q[8:6];
    else if (cmd.read_s) rf_raddr = insn[2:0];
    else if (cmd.read_t) rf_raddr = insn[11:9];
  end

  assign rf_we    = cmd.clear || (cmd.commit && ok && wr);
  assign rf_waddr = cmd.clear ? clr_addr[2:0] : rd;
  assign rf_wdata = cmd.clear ? 16'h0000 : val;

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_waddr] <= rf_wdata;
    rf_q <= rf[rf_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      ld_addr <= load_address;
      ld_data <= load_data;
    end
    if (cmd.decode) insn <= mem_q;
    if (cmd.read_s) rs   <= rf_q;
    if (cmd.read_t) rt   <= rf_q;
    if (cmd.read_d) rdv  <= rf_q;
    if (cmd.addr)   r7   <= rf_q;
    if (cmd.exec)   ldv  <= mem_q;
  end

  // execute
  always_comb begin
    val     = '0;
    wr      = 1'b0;
    rd      = d;
    setcc   = 1'b0;
    memw    = 1'b0;
    nxt     = pc_inc;
    psr_new = psr;
    addr_o  = '0;
    stat    = STAT_OK;
    if ((pc >= USER_DATA && pc < OS_CODE) || (pc >= OS_DATA && pc < OS_TOP))
      stat = STAT_PC_DATA;
    else if (!psr[15] && pc >= OS_CODE)
      stat = STAT_PRIV;

    case (op)
      OP_BR: begin
        if ((d & psr[2:0]) != 3'b000) nxt = pc_inc + {{7{insn[8]}}, insn[8:0]};
      end
      OP_ARITH: begin
        wr = 1'b1; setcc = 1'b1;
        if (insn[5]) val = rs + {{11{insn[4]}}, insn[4:0]};
        else begin
          case (insn[5:3])
            ARITH_ADD: val = rs + rt;
            ARITH_MUL: val = prod[15:0];
            ARITH_SUB: val = rs - rt;
            default:   val = (rt != 16'h0000) ? quo : 16'h0000;
          endcase
        end
      end
      OP_CMP: begin
        setcc = 1'b1;
        case (insn[8:7])
          CMP_S:   val = cmp3({rdv[15], rdv}, {rt[15], rt});
          CMP_U:   val = cmp3({1'b0, rdv}, {1'b0, rt});
          CMP_SI:  val = cmp3({rdv[15], rdv}, {{10{insn[6]}}, insn[6:0]});
          default: val = cmp3({1'b0, rdv}, {10'b0, insn[6:0]});
        endcase
      end
      OP_JSR: begin
        wr = 1'b1; rd = 3'd7; setcc = 1'b1; val = pc_inc;
        nxt = insn[11] ? {pc[15], insn[10:0], 4'b0000} : rs;
      end
      OP_LOGIC: begin
        wr = 1'b1; setcc = 1'b1;
        if (insn[5]) val = rs & {{11{insn[4]}}, insn[4:0]};
        else begin
          case (insn[5:3])
            LOGIC_AND: val = rs & rt;
            LOGIC_NOT: val = ~rs;
            LOGIC_OR:  val = rs | rt;
            default:   val = rs ^ rt;
          endcase
        end
      end
      OP_LDR, OP_STR: begin
        addr_o = ea;
        if (stat == STAT_OK) begin
          if (!psr[15] && ea >= OS_DATA) stat = STAT_PRIV;
          else if (ea < USER_DATA || (ea >= OS_CODE && ea < OS_DATA)) stat = STAT_BAD_ADR;
        end
        if (op == OP_LDR) begin
          wr = 1'b1; setcc = 1'b1; val = ldv;
        end else begin
          memw = 1'b1;
        end
      end
      OP_RTI: begin
        nxt = r7;
        psr_new[15] = 1'b0;
      end
      OP_CONST: begin
        wr = 1'b1; setcc = 1'b1; val = {{7{insn[8]}}, insn[8:0]};
      end
      OP_SHIFT: begin
        wr = 1'b1; setcc = 1'b1;
        case (insn[5:4])
          SH_SLL:  val = rs << insn[3:0];
          SH_SRA:  val = 16'($signed(rs) >>> insn[3:0]);
          SH_SRL:  val = rs >> insn[3:0];
          default: val = (rt != 16'h0000) ? rmd : 16'h0000;
        endcase
      end
      OP_JMP: begin
        nxt = insn[11] ? pc_inc + {{5{insn[10]}}, insn[10:0]} : rs;
      end
      OP_HICONST: begin
        wr = 1'b1; setcc = 1'b1; val = {insn[7:0], rdv[7:0]};
      end
      OP_TRAP: begin
        wr = 1'b1; rd = 3'd7; setcc = 1'b1; val = pc_inc;
        nxt = {8'h80, insn[7:0]};
        psr_new[15] = 1'b1;
      end
      default: ;
    endcase
    if (setcc) psr_new[2:0] = cond_of(val);
  end

  assign ok = stat == STAT_OK;

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= PC_RESET;
      psr <= PSR_RESET;
    end else if (cmd.commit && ok) begin
      pc  <= nxt;
      psr <= psr_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_wr || cmd.commit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      status      <= STAT_OK;
      pc_before   <= pc;
      instruction <= '0;
      next_pc     <= pc;
      reg_write   <= 1'b0;
      reg_dest    <= '0;
      reg_value   <= '0;
      mem_write   <= 1'b1;
      mem_address <= ld_addr;
      mem_data    <= ld_data;
      nzp         <= psr[2:0];
      privileged  <= psr[15];
    end else if (cmd.commit) begin
      status      <= stat;
      pc_before   <= pc;
      instruction <= insn;
      mem_address <= addr_o;
      next_pc     <= ok ? nxt : pc;
      reg_write   <= ok && wr;
      reg_dest    <= (ok && wr) ? rd : 3'd0;
      reg_value   <= (ok && wr) ? val : 16'h0000;
      mem_write   <= ok && memw;
      mem_data    <= (ok && memw) ? rdv : 16'h0000;
      nzp         <= ok ? psr_new[2:0] : psr[2:0];
      privileged  <= ok ? psr_new[15] : psr[15];
    end
  end

  a_psr_cc_onehot : assert property (@(posedge clk) disable iff (rst)
    $onehot(psr[2:0])) else $error("condition bits not one-hot");

  a_fault_keeps_pc : assert property (@(posedge clk) disable iff (rst)
    cmd.commit && !ok |=> pc == $past(pc) && psr == $past(psr))
    else $error("faulting instruction changed state");

  a_commit_gives_result : assert property (@(posedge clk) disable iff (rst)
    cmd.commit || cmd.load_wr |=> out_valid) else $error("result lost");
endmodule

// ----- design/lc4_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc4_ctrl
// Sequencer: memory clear, load transaction and fetch/decode/execute steps.
// ----------------------------------------------------------------------------
module lc4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              command,
  output logic              in_ready,
  input  lc4_pkg::dp_stat_t st,
  output lc4_pkg::dp_cmd_t  cmd
);
  import lc4_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) state_next = (command == CMD_LOAD) ? ST_LOAD : ST_FETCH;
      end
      ST_LOAD: begin
        // hold until the previous result is taken
        if (!st.out_full) begin
          cmd.load_wr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_next = ST_READ_S;
      end
      ST_READ_S: begin
        cmd.read_s = 1'b1;
        state_next = ST_READ_T;
      end
      ST_READ_T: begin
        cmd.read_t = 1'b1;
        state_next = ST_READ_D;
      end
      ST_READ_D: begin
        cmd.read_d = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = st.is_divmod ? ST_DIV : ST_COMMIT;
      end
      ST_DIV: begin
        if (!st.div_busy) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!st.out_full) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ----- design/lc4_instruction_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc4_instruction_step
// 16-bit teaching processor, one instruction or memory load per transaction.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole memory to zero, one word a cycle,
// and takes no transaction until done. A load command passes through the
// load state to the result register. A step command runs through fetch,
// decode, four register file reads through its single read port, data
// read, execute and commit. DIV and MOD also wait in the divide state for
// the one-bit-per-cycle divider. The result register holds a finished
// result while the next transaction is accepted; commit waits only if that
// result has not yet been taken.
module lc4_instruction_step #(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [15:0] load_address,
  input  logic [15:0] load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] pc_before,
  output logic [15:0] instruction,
  output logic [15:0] next_pc,
  output logic        reg_write,
  output logic [2:0]  reg_dest,
  output logic [15:0] reg_value,
  output logic        mem_write,
  output logic [15:0] mem_address,
  output logic [15:0] mem_data,
  output logic [2:0]  nzp,
  output logic        privileged
);
  import lc4_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  lc4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lc4_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .load_address (load_address),
    .load_data    (load_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .status       (status),
    .pc_before    (pc_before),
    .instruction  (instruction),
    .next_pc      (next_pc),
    .reg_write    (reg_write),
    .reg_dest     (reg_dest),
    .reg_value    (reg_value),
    .mem_write    (mem_write),
    .mem_address  (mem_address),
    .mem_data     (mem_data),
    .nzp          (nzp),
    .privileged   (privileged)
  );
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the instruction step processor: writes random
// instruction words into memory at the program counter, steps through
// them under random handshake idling and compares every trace field against
// an in-bench model of registers, status word and memory.
// ----------------------------------------------------------------------------
module tb;
  import lc4_pkg::*;

  localparam int ITEM_TARGET = 1700;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pc_before;
    logic [15:0] instruction;
    logic [15:0] next_pc;
    logic        reg_write;
    logic [2:0]  reg_dest;
    logic [15:0] reg_value;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [15:0] mem_data;
    logic [2:0]  nzp;
    logic        privileged;
  } trace_t;

  class trace_board;
    logic [15:0] pc_q;
    logic [15:0] psr_q;
    logic [15:0] regs [8];
    logic [15:0] mem [65536];
    trace_t      pending_traces [$];
    int          errors;

    function new();
      pc_q = PC_RESET;
      psr_q = PSR_RESET;
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      errors = 0;
    endfunction

    function logic [15:0] order3(logic signed [16:0] x, logic signed [16:0] y);
      if (x > y) return 16'h0001;
      if (x == y) return 16'h0000;
      return 16'hFFFF;
    endfunction

    function logic [2:0] sign_bits(logic [15:0] v);
      if (v == 16'h0000) return 3'b010;
      return v[15] ? 3'b100 : 3'b001;
    endfunction

    function bit in_data_region(logic [15:0] a);
      return (a >= USER_DATA && a < OS_CODE) || (a >= OS_DATA && a < OS_TOP);
    endfunction

    // Work out one trace; apply it to the state only when commit is set.
    function trace_t execute(logic cmd, logic [15:0] a, logic [15:0] w, bit commit);
      trace_t t;
      logic [15:0] pc, insn, nxt, val, addr, md, psr, rs, rt, rdv;
      logic [3:0] op;
      logic [2:0] d, s, ti, rd, sub3;
      logic [1:0] st, sub2;
      bit wr, mw, cc, priv;
      t = '0;
      pc = pc_q;
      psr = psr_q;
      t.pc_before = pc;
      if (cmd == CMD_LOAD) begin
        if (commit) mem[a] = w;
        t.status = STAT_OK;
        t.next_pc = pc;
        t.mem_write = 1'b1;
        t.mem_address = a;
        t.mem_data = w;
        t.nzp = psr[2:0];
        t.privileged = psr[15];
        return t;
      end
      insn = mem[pc];
      op = insn[15:12];
      d = insn[11:9];
      s = insn[8:6];
      ti = insn[2:0];
      priv = psr[15];
      nxt = pc + 16'd1;
      rs = regs[s];
      rt = regs[ti];
      rdv = regs[d];
      val = '0; addr = '0; md = '0; rd = '0;
      wr = 0; mw = 0; cc = 0;
      st = STAT_OK;
      if (in_data_region(pc)) st = STAT_PC_DATA;
      else if (!priv && pc >= OS_CODE) st = STAT_PRIV;
      case (op)
        OP_BR: if ((d & psr[2:0]) != 0) nxt = pc + 16'd1 + {{7{insn[8]}}, insn[8:0]};
        OP_ARITH: begin
          sub3 = insn[5:3];
          wr = 1; rd = d; cc = 1;
          if (insn[5]) val = rs + {{11{insn[4]}}, insn[4:0]};
          else if (sub3 == ARITH_ADD) val = rs + rt;
          else if (sub3 == ARITH_MUL) val = rs * rt;
          else if (sub3 == ARITH_SUB) val = rs - rt;
          else val = (rt != 0) ? rs / rt : 16'd0;
        end
        OP_CMP: begin
          sub2 = insn[8:7];
          cc = 1;
          if (sub2 == CMP_S) val = order3({rdv[15], rdv}, {rt[15], rt});
          else if (sub2 == CMP_U) val = order3({1'b0, rdv}, {1'b0, rt});
          else if (sub2 == CMP_SI) val = order3({rdv[15], rdv}, {{11{insn[6]}}, insn[5:0]});
          else val = order3({1'b0, rdv}, {10'd0, insn[6:0]});
        end
        OP_JSR: begin
          wr = 1; rd = 3'd7; cc = 1; val = pc + 16'd1;
          nxt = insn[11] ? {pc[15], insn[10:0], 4'd0} : rs;
        end
        OP_LOGIC: begin
          sub3 = insn[5:3];
          wr = 1; rd = d; cc = 1;
          if (insn[5]) val = rs & {{11{insn[4]}}, insn[4:0]};
          else if (sub3 == LOGIC_AND) val = rs & rt;
          else if (sub3 == LOGIC_NOT) val = ~rs;
          else if (sub3 == LOGIC_OR) val = rs | rt;
          else val = rs ^ rt;
        end
        OP_LDR, OP_STR: begin
          addr = rs + {{10{insn[5]}}, insn[5:0]};
          if (st == STAT_OK) begin
            if (!priv && addr >= OS_DATA) st = STAT_PRIV;
            else if (addr < USER_DATA || (addr >= OS_CODE && addr < OS_DATA)) st = STAT_BAD_ADR;
          end
          if (op == OP_LDR) begin
            wr = 1; rd = d; cc = 1; val = mem[addr];
          end else begin
            mw = 1; md = rdv;
          end
        end
        OP_RTI: begin
          nxt = regs[7];
          psr[15] = 1'b0;
        end
        OP_CONST: begin
          wr = 1; rd = d; cc = 1; val = {{7{insn[8]}}, insn[8:0]};
        end
        OP_SHIFT: begin
          sub2 = insn[5:4];
          wr = 1; rd = d; cc = 1;
          if (sub2 == SH_SLL) val = rs << insn[3:0];
          else if (sub2 == SH_SRA) val = $unsigned($signed(rs) >>> insn[3:0]);
          else if (sub2 == SH_SRL) val = rs >> insn[3:0];
          else val = (rt != 0) ? rs % rt : 16'd0;
        end
        OP_JMP: nxt = insn[11] ? pc + 16'd1 + {{5{insn[10]}}, insn[10:0]} : rs;
        OP_HICONST: begin
          wr = 1; rd = d; cc = 1; val = {insn[7:0], rdv[7:0]};
        end
        OP_TRAP: begin
          wr = 1; rd = 3'd7; cc = 1; val = pc + 16'd1;
          nxt = {8'h80, insn[7:0]};
          psr[15] = 1'b1;
        end
        default: ;
      endcase
      t.status = st;
      t.instruction = insn;
      t.mem_address = addr;
      if (st != STAT_OK) begin
        t.next_pc = pc;
        t.nzp = psr_q[2:0];
        t.privileged = psr_q[15];
        return t;
      end
      if (cc) psr[2:0] = sign_bits(val);
      if (commit) begin
        if (wr) regs[rd] = val;
        if (mw) mem[addr] = md;
        pc_q = nxt;
        psr_q = psr;
      end
      t.next_pc = nxt;
      t.reg_write = wr;
      t.reg_dest = wr ? rd : 3'd0;
      t.reg_value = wr ? val : 16'd0;
      t.mem_write = mw;
      t.mem_data = mw ? md : 16'd0;
      t.nzp = psr[2:0];
      t.privileged = psr[15];
      return t;
    endfunction

    // A state the processor can never leave: every later step faults.
    function bit would_trap_forever(logic [15:0] cand);
      logic [15:0] saved;
      trace_t t;
      saved = mem[pc_q];
      mem[pc_q] = cand;
      t = execute(CMD_STEP, '0, '0, 0);
      mem[pc_q] = saved;
      return in_data_region(t.next_pc) || (!t.privileged && t.next_pc >= OS_CODE);
    endfunction

    function void note_command(logic cmd, logic [15:0] a, logic [15:0] w);
      pending_traces.push_back(execute(cmd, a, w, 1));
    endfunction

    function void field_diff(string name, logic [15:0] e, logic [15:0] g);
      if (e !== g) begin
        $error("%s mismatch: expected %h, got %h", name, e, g);
        errors++;
      end
    endfunction

    function void check_trace(trace_t g);
      trace_t e;
      if (pending_traces.size() == 0) begin
        $error("trace with no outstanding transaction: pc_before %h", g.pc_before);
        errors++;
        return;
      end
      e = pending_traces.pop_front();
      field_diff("status", 16'(e.status), 16'(g.status));
      field_diff("pc_before", e.pc_before, g.pc_before);
      field_diff("instruction", e.instruction, g.instruction);
      field_diff("next_pc", e.next_pc, g.next_pc);
      field_diff("reg_write", 16'(e.reg_write), 16'(g.reg_write));
      field_diff("reg_dest", 16'(e.reg_dest), 16'(g.reg_dest));
      field_diff("reg_value", e.reg_value, g.reg_value);
      field_diff("mem_write", 16'(e.mem_write), 16'(g.mem_write));
      field_diff("mem_address", e.mem_address, g.mem_address);
      field_diff("mem_data", e.mem_data, g.mem_data);
      field_diff("nzp", 16'(e.nzp), 16'(g.nzp));
      field_diff("privileged", 16'(e.privileged), 16'(g.privileged));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid, in_ready;
  logic        command;
  logic [15:0] load_address, load_data;
  logic        out_valid, out_ready;
  logic [1:0]  status;
  logic [15:0] pc_before, instruction, next_pc, reg_value, mem_address, mem_data;
  logic        reg_write, mem_write, privileged;
  logic [2:0]  reg_dest, nzp;

  trace_board board = new();
  int  sent = 0;
  int  cycles = 0;
  bit  send_quiet = 0;
  bit  recv_quiet = 0;

  lc4_instruction_step u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .load_address(load_address), .load_data(load_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .pc_before(pc_before), .instruction(instruction),
    .next_pc(next_pc), .reg_write(reg_write), .reg_dest(reg_dest),
    .reg_value(reg_value), .mem_write(mem_write), .mem_address(mem_address),
    .mem_data(mem_data), .nzp(nzp), .privileged(privileged)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_trace('{status, pc_before, instruction, next_pc, reg_write, reg_dest,
                          reg_value, mem_write, mem_address, mem_data, nzp, privileged});
  end

  // Result side: random stall before each transaction, with quiet stretches.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < 2) recv_quiet = !recv_quiet;
      if (!recv_quiet) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send(logic cmd, logic [15:0] a, logic [15:0] w);
    if ($urandom_range(0, 99) < 2) send_quiet = !send_quiet;
    if (!send_quiet) repeat ($urandom_range(0, 17)) @(negedge clk);
    command = cmd;
    load_address = a;
    load_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_command(cmd, a, w);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Place a word at the program counter and run it.
  task automatic run_word(logic [15:0] w);
    send(CMD_LOAD, board.pc_q, w);
    send(CMD_STEP, 16'($urandom), 16'($urandom));
  endtask

  task automatic random_step();
    logic [15:0] cand;
    int tries;
    tries = 0;
    cand = 16'($urandom);
    while (board.would_trap_forever(cand) && tries < 20) begin
      cand = 16'($urandom);
      tries++;
    end
    // branch to self on any condition keeps the program counter safe
    if (board.would_trap_forever(cand)) cand = {OP_BR, 3'b111, 9'h1FF};
    run_word(cand);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_LOAD;
    load_address = '0;
    load_data = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: address and data extremes, divide and modulo by zero,
    // source equal to destination, arithmetic shift of a negative, unused opcode
    send(CMD_LOAD, 16'hFFFF, 16'hFFFF);
    send(CMD_LOAD, 16'h0000, 16'h0000);
    run_word(16'h1218);
    run_word(16'hA430);
    run_word(16'h97FF);
    run_word(16'h16C3);
    run_word(16'h18CB);
    run_word(16'hAADF);
    run_word(16'h2600);
    run_word(16'h3000);
    send(CMD_STEP, 16'hFFFF, 16'hFFFF);

    while (sent < ITEM_TARGET) begin
      if (sent > ITEM_TARGET / 2 && sent < ITEM_TARGET / 2 + 3)
        while (board.pending_traces.size() != 0) @(negedge clk);
      case ($urandom_range(0, 9))
        0: send(CMD_LOAD, 16'($urandom), 16'($urandom));
        1: begin
          if (!board.would_trap_forever(board.mem[board.pc_q])) send(CMD_STEP, '0, '0);
          else random_step();
        end
        default: random_step();
      endcase
    end

    // tail: drop to user mode, then jump into a data region and stay there
    if (!board.psr_q[15]) run_word({OP_TRAP, 12'h000});
    run_word(16'h9E30);
    run_word(16'hDE00);
    run_word({OP_RTI, 12'h000});
    run_word(16'h9200);
    run_word(16'hD225);
    run_word(16'hC040);
    send(CMD_STEP, '0, '0);
    send(CMD_STEP, '0, '0);

    while (board.pending_traces.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending_traces.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
